/* design/mwms_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package mwms_pkg;

  localparam int VALUE_BITS = 16;
  localparam int MAX_SIDE   = 64;
  localparam int SIDE_BITS  = $clog2(MAX_SIDE);
  localparam int ADDR_BITS  = 2 * SIDE_BITS;
  localparam int GRID_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int CNT_BITS   = ADDR_BITS + 1;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int BOUND_BITS = VALUE_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;

  // Window corner selects for the four prefix lookups
  localparam logic [1:0] CRN_BR = 2'd0;  // (i, j)
  localparam logic [1:0] CRN_TR = 2'd1;  // (i-k, j)
  localparam logic [1:0] CRN_BL = 2'd2;  // (i, j-k)
  localparam logic [1:0] CRN_TL = 2'd3;  // (i-k, j-k)

  typedef struct packed {
    logic       load_wr;
    logic       search_init;
    logic       probe_init;
    logic       p1_issue;
    logic       p1_write;
    logic       p2_init;
    logic       p2_issue;
    logic [1:0] issue_sel;
    logic       p2_acc;
    logic [1:0] acc_sel;
    logic       p2_check;
    logic       probe_end;
    logic       result_load;
  } mwms_cmd_t;

  typedef struct packed {
    logic load_done;
    logic last_cell;
    logic win_fits;
    logic cell_fail;
    logic search_more;
  } mwms_sts_t;

endpackage

/* design/min_window_median_search_unit.sv */
// Top level of the windowed upper-median minimum search.
`timescale 1ns / 1ps
// Loads a side_len by side_len grid one value per transaction, row-major.
// The transaction that completes the grid starts a binary search over
// thresholds (up to 17 probes). Each probe makes one pass over the grid
// building 2D prefix counts (a read state and a write state per cell) and,
// when the window fits, a second pass checking every window (four corner
// lookups and a check per window position, ending at the first failing
// window). Values that do not complete a grid are accepted while no search
// runs. The result sits in an output register; loading of the next grid
// continues while it waits, only the completing transaction is held. No
// clearing pass is needed after reset.
module min_window_median_search_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mwms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mwms_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mwms_pkg::VALUE_BITS-1:0]     in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mwms_pkg::VALUE_BITS-1:0]     out_min_median
);
  import mwms_pkg::*;

  mwms_cmd_t cmd;
  mwms_sts_t sts;

  // Sequencer
  mwms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  mwms_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_value       (in_value),
    .out_min_median (out_min_median),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

/* design/mwms_ctrl.sv */
// Sequencer for loading, threshold probes and result handoff.
`timescale 1ns / 1ps
module mwms_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  mwms_pkg::mwms_sts_t sts,
  output mwms_pkg::mwms_cmd_t cmd
);
  import mwms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TEST, S_P1_RD, S_P1_WR, S_P2_A0, S_P2_A1, S_P2_A2, S_P2_A3,
    S_P2_CHK, S_P_END
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  // Hold off all input during a search, and the grid-completing transaction while a result is still pending
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && sts.load_done);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_wr = 1'b1;
          if (sts.load_done) begin
            cmd.search_init = 1'b1;
            state_nxt       = S_TEST;
          end
        end
      end
      S_TEST: begin
        if (sts.search_more) begin
          cmd.probe_init = 1'b1;
          state_nxt      = S_P1_RD;
        end else begin
          cmd.result_load = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_P1_RD: begin
        cmd.p1_issue = 1'b1;
        state_nxt    = S_P1_WR;
      end
      S_P1_WR: begin
        cmd.p1_write = 1'b1;
        if (sts.last_cell) begin
          if (sts.win_fits) begin
            cmd.p2_init = 1'b1;
            state_nxt   = S_P2_A0;
          end else begin
            state_nxt = S_P_END;
          end
        end else begin
          state_nxt = S_P1_RD;
        end
      end
      S_P2_A0: begin
        cmd.p2_issue  = 1'b1;
        cmd.issue_sel = CRN_BR;
        state_nxt     = S_P2_A1;
      end
      S_P2_A1: begin
        cmd.p2_acc    = 1'b1;
        cmd.acc_sel   = CRN_BR;
        cmd.p2_issue  = 1'b1;
        cmd.issue_sel = CRN_TR;
        state_nxt     = S_P2_A2;
      end
      S_P2_A2: begin
        cmd.p2_acc    = 1'b1;
        cmd.acc_sel   = CRN_TR;
        cmd.p2_issue  = 1'b1;
        cmd.issue_sel = CRN_BL;
        state_nxt     = S_P2_A3;
      end
      S_P2_A3: begin
        cmd.p2_acc    = 1'b1;
        cmd.acc_sel   = CRN_BL;
        cmd.p2_issue  = 1'b1;
        cmd.issue_sel = CRN_TL;
        state_nxt     = S_P2_CHK;
      end
      S_P2_CHK: begin
        cmd.p2_check = 1'b1;
        state_nxt    = (sts.cell_fail || sts.last_cell) ? S_P_END : S_P2_A0;
      end
      S_P_END: begin
        cmd.probe_end = 1'b1;
        state_nxt     = S_TEST;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/mwms_dp.sv */
// Grid store, prefix count memory, search bounds and window check.
`timescale 1ns / 1ps
module mwms_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [mwms_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mwms_pkg::CFG_W-1:0]            cfg_data,
  input  logic [mwms_pkg::VALUE_BITS-1:0]       in_value,
  output logic [mwms_pkg::VALUE_BITS-1:0]       out_min_median,
  input  mwms_pkg::mwms_cmd_t                   cmd,
  output mwms_pkg::mwms_sts_t                   sts
);
  import mwms_pkg::*;

  logic [VALUE_BITS-1:0] g_mem [GRID_DEPTH];
  logic [CNT_BITS-1:0]   p_mem [GRID_DEPTH];

  logic [CFG_W-1:0]      side_r, win_r, n, k;
  logic [CNT_BITS-1:0]   load_cnt_r, load_cnt_nxt;
  logic [ADDR_BITS-1:0]  idx;
  logic [CNT_BITS-1:0]   idx_p1, nn;
  logic [2*CFG_W-1:0]    nn_full, kk_full, need;
  logic [BOUND_BITS-1:0] low_p1_r, high_r;
  logic [BOUND_BITS:0]   mid_sum;
  logic [VALUE_BITS-1:0] mid, g_rd_r, res_r;
  logic [CNT_BITS-1:0]   p_rd_r, above, term, acc_r, cnt, p_wdata;
  logic [CFG_W-1:0]      i_r, j_r, row_r, row_nxt, r_sel, c_sel;
  logic [ADDR_BITS-1:0]  g_addr_r, p_raddr, p_waddr;
  logic                  zero_r, fail_r, hit, minus;

  // Effective grid side and window
  always_comb begin
    n = side_r;
    if (side_r == '0) n = CFG_W'(1);
    else if (side_r > CFG_W'(MAX_SIDE)) n = CFG_W'(MAX_SIDE);
    k = (win_r == '0) ? CFG_W'(1) : win_r;
  end

  assign nn_full = n * n;
  assign nn      = nn_full[CNT_BITS-1:0];
  assign kk_full = k * k;
  assign need    = (kk_full >> 1) + (2*CFG_W)'(1);

  // Load position, wrapping to zero once the grid is complete
  assign idx    = load_cnt_r[CNT_BITS-1] ? '0 : load_cnt_r[ADDR_BITS-1:0];
  assign idx_p1 = {1'b0, idx} + CNT_BITS'(1);
  assign load_cnt_nxt = (idx_p1 >= nn) ? '0 : idx_p1;

  // Probe threshold
  assign mid_sum = {1'b0, low_p1_r} + {1'b0, high_r} - (BOUND_BITS+1)'(1);
  assign mid     = mid_sum[VALUE_BITS:1];

  // Row prefix step for pass one
  assign hit     = g_rd_r >= mid;
  assign row_nxt = row_r + CFG_W'(hit);
  assign above   = (i_r == CFG_W'(1)) ? '0 : p_rd_r;
  assign p_wdata = above + CNT_BITS'(row_nxt);
  assign p_waddr = {SIDE_BITS'(i_r - CFG_W'(1)), SIDE_BITS'(j_r - CFG_W'(1))};

  // Corner lookup for pass two
  assign r_sel = cmd.issue_sel[0] ? (i_r - k) : i_r;
  assign c_sel = cmd.issue_sel[1] ? (j_r - k) : j_r;
  always_comb begin
    if (cmd.p2_issue) begin
      p_raddr = {SIDE_BITS'(r_sel - CFG_W'(1)), SIDE_BITS'(c_sel - CFG_W'(1))};
    end else begin
      p_raddr = {SIDE_BITS'(i_r - CFG_W'(2)), SIDE_BITS'(j_r - CFG_W'(1))};
    end
  end

  assign term  = zero_r ? '0 : p_rd_r;
  assign minus = cmd.acc_sel[0] ^ cmd.acc_sel[1];
  assign cnt   = acc_r + term;

  assign sts.load_done   = idx_p1 >= nn;
  assign sts.last_cell   = (i_r == n) && (j_r == n);
  assign sts.win_fits    = k <= n;
  assign sts.cell_fail   = {1'b0, cnt} < need;
  assign sts.search_more = high_r > low_p1_r;
  assign out_min_median  = res_r;

  // Grid store
  always_ff @(posedge clk) begin
    if (cmd.load_wr) g_mem[idx] <= in_value;
    if (cmd.p1_issue) g_rd_r <= g_mem[g_addr_r];
  end

  // Prefix count memory
  always_ff @(posedge clk) begin
    if (cmd.p1_write) p_mem[p_waddr] <= p_wdata;
    if (cmd.p1_issue || cmd.p2_issue) begin
      p_rd_r <= p_mem[p_raddr];
      zero_r <= (r_sel == '0) || (c_sel == '0);
    end
  end

  // Configuration and control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r     <= CFG_W'(MAX_SIDE);
      win_r      <= CFG_W'(1);
      load_cnt_r <= '0;
      low_p1_r   <= '0;
      high_r     <= BOUND_BITS'(1) << VALUE_BITS;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SIDE_LEN: side_r <= cfg_data;
          CFG_WINDOW:   win_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_wr) load_cnt_r <= load_cnt_nxt;
      if (cmd.search_init) begin
        low_p1_r <= '0;
        high_r   <= BOUND_BITS'(1) << VALUE_BITS;
      end else if (cmd.probe_end) begin
        if (fail_r) high_r <= BOUND_BITS'(mid);
        else        low_p1_r <= BOUND_BITS'(mid) + BOUND_BITS'(1);
      end
    end
  end

  // Scan position, row count, accumulator and fail flag
  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      i_r      <= CFG_W'(1);
      j_r      <= CFG_W'(1);
      g_addr_r <= '0;
      row_r    <= '0;
      fail_r   <= 1'b0;
    end else if (cmd.p2_init) begin
      i_r <= k;
      j_r <= k;
    end else if (cmd.p1_write) begin
      g_addr_r <= g_addr_r + ADDR_BITS'(1);
      if (j_r == n) begin
        j_r   <= CFG_W'(1);
        i_r   <= i_r + CFG_W'(1);
        row_r <= '0;
      end else begin
        j_r   <= j_r + CFG_W'(1);
        row_r <= row_nxt;
      end
    end else if (cmd.p2_check) begin
      fail_r <= fail_r | sts.cell_fail;
      if (j_r == n) begin
        j_r <= k;
        i_r <= i_r + CFG_W'(1);
      end else begin
        j_r <= j_r + CFG_W'(1);
      end
    end
    if (cmd.p2_acc) begin
      if (cmd.acc_sel == CRN_BR) acc_r <= term;
      else if (minus)            acc_r <= acc_r - term;
      else                       acc_r <= acc_r + term;
    end
    if (cmd.result_load) res_r <= VALUE_BITS'(low_p1_r - BOUND_BITS'(1));
  end

endmodule

/* design/mwms_checker.sv */
// Port-level checks for the search unit, bound to the top level.
`timescale 1ns / 1ps
module mwms_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [mwms_pkg::VALUE_BITS-1:0] out_min_median
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_median))
    else $error("stalled result changed");

  // Drop the result after reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result only follows a busy search
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a search");

  // One result per search
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

endmodule

bind min_window_median_search_unit mwms_checker u_mwms_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_min_median (out_min_median)
);

/* verif/min_window_median_search_unit_test.sv */
// Self-checking testbench for the windowed upper-median minimum search unit.
`timescale 1ns / 1ps
module min_window_median_search_unit_test;
  import mwms_pkg::*;

  // Tracks the loaded grid and registers, predicts each search result
  class median_scoreboard;
    logic [VALUE_BITS-1:0] grid_vals [GRID_DEPTH];
    int unsigned           fill;
    logic [CFG_W-1:0]      side_reg;
    logic [CFG_W-1:0]      win_reg;
    logic [VALUE_BITS-1:0] pending_medians [$];
    int                    mismatches;
    int                    results_seen;

    function new();
      fill = 0;
      side_reg = 7'd64;
      win_reg = 7'd1;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_SIDE_LEN) side_reg = data;
      else if (idx == CFG_WINDOW) win_reg = data;
    endfunction

    function int unsigned grid_side();
      if (side_reg == 0) return 1;
      if (side_reg > MAX_SIDE) return MAX_SIDE;
      return side_reg;
    endfunction

    // True when some window holds too few cells at or above the threshold
    function bit window_short(int unsigned n, int unsigned k, int thr);
      int unsigned pc [(MAX_SIDE + 1) * (MAX_SIDE + 1)];
      int unsigned row;
      int unsigned need;
      int unsigned cnt;
      int s;
      need = (k * k) / 2 + 1;
      s = MAX_SIDE + 1;
      for (int j = 0; j <= n; j++) pc[j] = 0;
      for (int i = 1; i <= n; i++) begin
        row = 0;
        pc[i * s] = 0;
        for (int j = 1; j <= n; j++) begin
          if (int'(grid_vals[(i - 1) * n + (j - 1)]) >= thr) row++;
          pc[i * s + j] = pc[(i - 1) * s + j] + row;
        end
      end
      if (k > n) return 0;
      for (int i = k; i <= n; i++) begin
        for (int j = k; j <= n; j++) begin
          cnt = pc[i * s + j] - pc[(i - k) * s + j] - pc[i * s + (j - k)]
              + pc[(i - k) * s + (j - k)];
          if (cnt < need) return 1;
        end
      end
      return 0;
    endfunction

    // Store one accepted value; a completed grid queues its search result
    function void note_value(logic [VALUE_BITS-1:0] v);
      int unsigned n;
      int unsigned k;
      int unsigned slot;
      int lo;
      int hi;
      int mid;
      n = grid_side();
      k = (win_reg == 0) ? 1 : win_reg;
      slot = (fill >= GRID_DEPTH) ? 0 : fill;
      grid_vals[slot] = v;
      fill = slot + 1;
      if (fill < n * n) return;
      fill = 0;
      lo = -1;
      hi = 1 << VALUE_BITS;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (window_short(n, k, mid)) hi = mid;
        else lo = mid;
      end
      pending_medians.push_back(lo[VALUE_BITS-1:0]);
    endfunction

    function void check_result(logic [VALUE_BITS-1:0] got);
      logic [VALUE_BITS-1:0] want;
      results_seen++;
      if (pending_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result min_median=%0d", got);
        return;
      end
      want = pending_medians.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("min_median mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [VALUE_BITS-1:0] out_min_median;

  median_scoreboard sb;
  bit               steady;
  bit               random_phase;
  bit               held_off;
  int unsigned      cycles;
  int unsigned      sent;

  min_window_median_search_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_min_median (out_min_median)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 5000000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stalls, with one long hold-off during the random phase
  initial begin
    int unsigned n;
    out_stall = 0;
    held_off = 0;
    @(posedge rst_n);
    forever begin
      if (!held_off && random_phase && sb.results_seen >= 3) begin
        held_off = 1;
        n = 600;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Check each accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_min_median);
  end

  task automatic send_value(logic [VALUE_BITS-1:0] v);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_value(v);
    sent++;
  endtask

  // Drain outstanding results, then let the block settle before a write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_medians.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, data);
  endtask

  function automatic logic [VALUE_BITS-1:0] rand_value(int unsigned mode);
    case (mode)
      0: return VALUE_BITS'($urandom_range(0, 3));
      1: return ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
      2: return VALUE_BITS'($urandom_range(100, 120));
      default: return VALUE_BITS'($urandom());
    endcase
  endfunction

  task automatic send_grid(int unsigned mode);
    int unsigned n;
    n = sb.grid_side();
    for (int i = 0; i < n * n; i++) send_value(rand_value(mode));
  endtask

  initial begin
    int unsigned side;
    int unsigned win;
    sb = new();
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_SIDE_LEN;
    cfg_data = 0;
    in_valid = 0;
    in_value = 0;
    steady = 0;
    random_phase = 0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Partial load at reset settings, then shrink the grid so it completes
    steady = 1;
    for (int i = 0; i < 40; i++) send_value(rand_value(3));
    steady = 0;
    write_reg(CFG_SIDE_LEN, 7'd6);
    send_value(rand_value(3));

    // Mid-size grid
    write_reg(CFG_SIDE_LEN, 7'd32);
    steady = 1;
    send_grid(3);
    steady = 0;

    // Saturated and zero side lengths, then a small grid
    write_reg(CFG_SIDE_LEN, 7'd127);
    write_reg(CFG_SIDE_LEN, 7'd0);
    write_reg(CFG_WINDOW, 7'd0);
    send_value(16'hFFFF);
    send_value(16'h0000);
    write_reg(CFG_SIDE_LEN, 7'd3);
    write_reg(CFG_WINDOW, 7'd2);
    send_grid(1);
    // Window larger than grid
    write_reg(CFG_WINDOW, 7'd64);
    send_grid(3);
    write_reg(CFG_WINDOW, 7'd127);
    write_reg(CFG_SIDE_LEN, 7'd2);
    send_grid(0);
    // Shrink the grid mid-load past the loaded count
    write_reg(CFG_WINDOW, 7'd2);
    write_reg(CFG_SIDE_LEN, 7'd4);
    for (int i = 0; i < 5; i++) send_value(rand_value(3));
    write_reg(CFG_SIDE_LEN, 7'd2);
    send_value(rand_value(3));
    write_reg(CFG_SIDE_LEN, 7'd1);
    write_reg(CFG_WINDOW, 7'd1);
    send_value(16'h8000);

    // Random grids, mostly small
    random_phase = 1;
    // Complete several one-cell grids while the receiver holds off
    for (int i = 0; i < 4; i++) send_value(rand_value(3));
    while (sent < 1800) begin
      steady = ($urandom_range(9) == 0);
      side = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
      win = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) :
            $urandom_range(1, (side == 0) ? 2 : side + 1);
      write_reg(CFG_SIDE_LEN, CFG_W'(side));
      write_reg(CFG_WINDOW, CFG_W'(win));
      send_grid($urandom_range(3));
    end
    steady = 0;
    in_valid <= 0;

    while (sb.pending_medians.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* min_window_median_search_unit.f */
design/mwms_pkg.sv
design/mwms_ctrl.sv
design/mwms_dp.sv
design/min_window_median_search_unit.sv
design/mwms_checker.sv
verif/min_window_median_search_unit_test.sv
